@@ sv/bmhq_pkg.sv @@
package bmhq_pkg;

    localparam int DEPTH  = 64;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 7;
    localparam int OCC_W  = 7;
    localparam int STAT_W = 2;
    // common width for count / capacity compares
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    // child index 2*pos+2 needs two bits over the address
    localparam int CH_W   = ADDR_W + 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key;
    } t_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic [STAT_W-1:0]       status;
        logic [OCC_W-1:0]        occupancy;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_RD,
        S_DN_CMP
    } t_state;

    typedef struct packed {
        logic load;
        logic begin_ins;
        logic begin_ext;
        logic fail;
        logic up_read;
        logic up_move;
        logic ext_take;
        logic dn_read;
        logic dn_move;
        logic place;
    } t_cmd;

    typedef struct packed {
        logic is_extract;
        logic full;
        logic empty;
        logic at_root;
        logic up_swap;
        logic is_leaf;
        logic dn_swap;
    } t_sts;

endpackage

@@ sv/bmhq_ram.sv @@
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ sv/bmhq_ctrl.sv @@
module bmhq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bmhq_pkg::t_sts  i_sts,
    output bmhq_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    bmhq_pkg::t_state r_state;
    bmhq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmhq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (i_start) n_state = bmhq_pkg::S_CHECK;
            end
            bmhq_pkg::S_CHECK: begin
                if (i_sts.is_extract) begin
                    n_state = i_sts.empty ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DN_LOAD;
                end else begin
                    n_state = i_sts.full ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP_RD;
                end
            end
            bmhq_pkg::S_UP_RD: begin
                n_state = i_sts.at_root ? bmhq_pkg::S_IDLE : bmhq_pkg::S_UP_CMP;
            end
            bmhq_pkg::S_UP_CMP: begin
                n_state = i_sts.up_swap ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_IDLE;
            end
            bmhq_pkg::S_DN_LOAD: begin
                n_state = bmhq_pkg::S_DN_RD;
            end
            bmhq_pkg::S_DN_RD: begin
                n_state = i_sts.is_leaf ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DN_CMP;
            end
            bmhq_pkg::S_DN_CMP: begin
                n_state = i_sts.dn_swap ? bmhq_pkg::S_DN_RD : bmhq_pkg::S_IDLE;
            end
            default: n_state = bmhq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != bmhq_pkg::S_IDLE);
        unique case (r_state)
            bmhq_pkg::S_IDLE: begin
                o_cmd.load = i_start;
            end
            bmhq_pkg::S_CHECK: begin
                if (i_sts.is_extract) begin
                    o_cmd.fail      = i_sts.empty;
                    o_cmd.begin_ext = !i_sts.empty;
                end else begin
                    o_cmd.fail      = i_sts.full;
                    o_cmd.begin_ins = !i_sts.full;
                end
            end
            bmhq_pkg::S_UP_RD: begin
                o_cmd.place   = i_sts.at_root;
                o_cmd.up_read = !i_sts.at_root;
            end
            bmhq_pkg::S_UP_CMP: begin
                o_cmd.up_move = i_sts.up_swap;
                o_cmd.place   = !i_sts.up_swap;
            end
            bmhq_pkg::S_DN_LOAD: begin
                o_cmd.ext_take = 1'b1;
            end
            bmhq_pkg::S_DN_RD: begin
                o_cmd.place   = i_sts.is_leaf;
                o_cmd.dn_read = !i_sts.is_leaf;
            end
            bmhq_pkg::S_DN_CMP: begin
                o_cmd.dn_move = i_sts.dn_swap;
                o_cmd.place   = !i_sts.dn_swap;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ sv/bmhq_dpath.sv @@
module bmhq_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmhq_pkg::t_item               i_item,
    input  bmhq_pkg::t_cmd                i_cmd,
    input  logic                          i_cfg_we,
    input  logic [bmhq_pkg::CAP_W-1:0]    i_cfg_data,
    output bmhq_pkg::t_sts                o_sts,
    output bmhq_pkg::t_result             o_result,
    output logic                          o_done
);

    localparam int KW = bmhq_pkg::KEY_W;
    localparam int AW = bmhq_pkg::ADDR_W;
    localparam int CW = bmhq_pkg::CNT_W;
    localparam int MW = bmhq_pkg::CMP_W;
    localparam int HW = bmhq_pkg::CH_W;

    logic                      r_func;
    logic signed [KW-1:0]      r_key;
    logic signed [KW-1:0]      r_value;
    logic [AW-1:0]             r_pos;
    logic [CW-1:0]             r_count;
    logic [bmhq_pkg::CAP_W-1:0] r_cap;
    bmhq_pkg::t_result         r_out;
    logic                      r_done;

    logic [MW-1:0]        cnt_x;
    logic [MW-1:0]        cap_x;
    logic [MW-1:0]        dep_x;
    logic [CW-1:0]        cnt_m1;
    logic [AW-1:0]        pos_m1;
    logic [AW-1:0]        parent;
    logic [HW-1:0]        lc;
    logic [HW-1:0]        rc;
    logic [HW-1:0]        cnt_ch;
    logic                 rc_ok;
    logic                 take_l;
    logic                 take_r;
    logic signed [KW-1:0] big_val;
    logic signed [KW-1:0] rd_a;
    logic signed [KW-1:0] rd_b;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [KW-1:0] wdata;
    logic [AW-1:0]        raddr_a;
    logic [AW-1:0]        raddr_b;

    bmhq_ram #(
        .WIDTH(KW),
        .DEPTH(bmhq_pkg::DEPTH)
    ) u_heap_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr_a(raddr_a),
        .i_raddr_b(raddr_b),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    assign cnt_x  = MW'(r_count);
    assign cap_x  = MW'(r_cap);
    assign dep_x  = MW'(bmhq_pkg::DEPTH);
    assign cnt_m1 = r_count - CW'(1);
    assign pos_m1 = r_pos - AW'(1);
    assign parent = {1'b0, pos_m1[AW-1:1]};
    assign lc     = {1'b0, r_pos, 1'b1};
    assign rc     = lc + HW'(1);
    assign cnt_ch = HW'(r_count);
    assign rc_ok  = (rc < cnt_ch);

    // sift-down pick: moving key vs left child, then winner vs right child
    assign take_l  = (r_key < rd_a);
    assign big_val = take_l ? rd_a : r_key;
    assign take_r  = rc_ok && (big_val < rd_b);

    assign o_sts.is_extract = (r_func == bmhq_pkg::FUNC_EXTRACT);
    assign o_sts.full       = (cnt_x >= cap_x) || (cnt_x >= dep_x);
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.at_root    = (r_pos == '0);
    assign o_sts.up_swap    = (rd_a < r_key);
    assign o_sts.is_leaf    = (lc >= cnt_ch);
    assign o_sts.dn_swap    = take_l || take_r;

    always_comb begin
        we      = i_cmd.place || i_cmd.up_move || i_cmd.dn_move;
        waddr   = r_pos;
        wdata   = r_key;
        raddr_a = '0;
        raddr_b = '0;
        if (i_cmd.up_move) begin
            wdata = rd_a;
        end else if (i_cmd.dn_move) begin
            wdata = take_r ? rd_b : rd_a;
        end
        if (i_cmd.begin_ext) begin
            raddr_b = cnt_m1[AW-1:0];
        end else if (i_cmd.up_read) begin
            raddr_a = parent;
        end else if (i_cmd.dn_read) begin
            raddr_a = lc[AW-1:0];
            raddr_b = rc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
            r_cap   <= bmhq_pkg::CAP_RESET;
        end else begin
            r_done <= i_cmd.place || i_cmd.fail;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.begin_ins) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.ext_take) begin
                r_count <= cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_item.func;
            r_key   <= i_item.key;
            r_value <= '0;
        end
        if (i_cmd.begin_ins) begin
            r_pos <= r_count[AW-1:0];
        end
        if (i_cmd.ext_take) begin
            r_value <= rd_a;
            r_key   <= rd_b;
            r_pos   <= '0;
        end
        if (i_cmd.up_move) begin
            r_pos <= parent;
        end
        if (i_cmd.dn_move) begin
            r_pos <= take_r ? rc[AW-1:0] : lc[AW-1:0];
        end
        if (i_cmd.place) begin
            r_out.value     <= r_value;
            r_out.status    <= bmhq_pkg::ST_OK;
            r_out.occupancy <= cnt_x[bmhq_pkg::OCC_W-1:0];
        end else if (i_cmd.fail) begin
            r_out.value     <= '0;
            r_out.status    <= (r_func == bmhq_pkg::FUNC_EXTRACT) ?
                               bmhq_pkg::ST_UNDERFLOW : bmhq_pkg::ST_OVERFLOW;
            r_out.occupancy <= cnt_x[bmhq_pkg::OCC_W-1:0];
        end
    end

    assign o_result = r_out;
    assign o_done   = r_done;

endmodule

@@ sv/binary_max_heap_queue.sv @@
// A refused insert (overflow) or extract (underflow) registers its result from the check
// state. An insert climbs from the new last slot and stops at the root or below a parent
// not smaller than its key; an extract moves the last item to the root and sifts it down
// until a leaf or until no child is larger; each level takes one read and one compare.
// One item at a time; busy drops in the cycle the result strobe is high.
// Result strobe lasts one cycle, no receiver stall. Sync active-low reset: empty, cap 64.
module binary_max_heap_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bmhq_pkg::t_item              i_item,
    output bmhq_pkg::t_result            o_result,
    output logic                         o_done,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bmhq_pkg::CAP_W-1:0]   i_cfg_data
);

    bmhq_pkg::t_cmd cmd;
    bmhq_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    bmhq_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    bmhq_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cmd     (cmd),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_data(i_cfg_data),
        .o_sts     (sts),
        .o_result  (o_result),
        .o_done    (o_done)
    );

endmodule

@@ sv/bmhq_checker.sv @@
module bmhq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input bmhq_pkg::t_result o_result
);

    localparam int OW = bmhq_pkg::OCC_W;
    localparam logic [OW-1:0] OCC_MAX = OW'(bmhq_pkg::DEPTH);

    // an accepted item keeps the block busy for at least the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted beat");

    // result beat marks the end of the operation
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.occupancy <= OCC_MAX))
        else $error("occupancy beyond depth");

    // underflow only from an empty heap, and it leaves it empty with value zero
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == bmhq_pkg::ST_UNDERFLOW))
            |-> ((o_result.occupancy == '0) && (o_result.value == '0)))
        else $error("underflow with nonzero occupancy or value");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_result.status == bmhq_pkg::ST_OK) ||
                    (o_result.status == bmhq_pkg::ST_OVERFLOW) ||
                    (o_result.status == bmhq_pkg::ST_UNDERFLOW)))
        else $error("undefined status code");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_result(o_result)
);

@@ dv/tb_binary_max_heap_queue.sv @@
`timescale 1ns / 1ps

module tb_binary_max_heap_queue;

    localparam int LIMIT           = 400000;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int MAX_GAP         = 18;
    localparam int KW              = bmhq_pkg::KEY_W;
    localparam int CPW             = bmhq_pkg::CAP_W;

    // Tracks the heap contents and capacity and keeps the results still owed by the block.
    class heap_tracker;
        logic signed [KW-1:0]  slots [bmhq_pkg::DEPTH];
        int                    held;
        logic [CPW-1:0]        capacity;
        bmhq_pkg::t_result     due_results [$];
        int                    fails;

        function new();
            held     = 0;
            capacity = bmhq_pkg::CAP_RESET;
            fails    = 0;
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t ns: %s", $time, msg);
            fails++;
        endtask

        function void note_item(bmhq_pkg::t_item it);
            bmhq_pkg::t_result     r;
            int                    lim;
            int                    pos;
            int                    lc;
            int                    big;
            logic signed [KW-1:0]  tmp;
            bit                    settled;
            r        = '0;
            r.status = bmhq_pkg::ST_OK;
            lim      = (capacity > bmhq_pkg::DEPTH) ? bmhq_pkg::DEPTH : int'(capacity);
            if (it.func == bmhq_pkg::FUNC_INSERT) begin
                if (held >= lim) begin
                    r.status = bmhq_pkg::ST_OVERFLOW;
                end else begin
                    slots[held] = it.key;
                    pos = held;
                    held++;
                    while (pos > 0 && slots[(pos - 1) / 2] < slots[pos]) begin
                        tmp                    = slots[(pos - 1) / 2];
                        slots[(pos - 1) / 2]   = slots[pos];
                        slots[pos]             = tmp;
                        pos                    = (pos - 1) / 2;
                    end
                end
            end else if (held == 0) begin
                r.status = bmhq_pkg::ST_UNDERFLOW;
            end else begin
                r.value  = slots[0];
                slots[0] = slots[held - 1];
                held--;
                pos     = 0;
                settled = 1'b0;
                while (!settled) begin
                    lc  = 2 * pos + 1;
                    big = pos;
                    if (lc < held && slots[big] < slots[lc]) big = lc;
                    if (lc + 1 < held && slots[big] < slots[lc + 1]) big = lc + 1;
                    if (big == pos) begin
                        settled = 1'b1;
                    end else begin
                        tmp        = slots[pos];
                        slots[pos] = slots[big];
                        slots[big] = tmp;
                        pos        = big;
                    end
                end
            end
            r.occupancy = bmhq_pkg::OCC_W'(held);
            due_results.push_back(r);
        endfunction

        task check_result(bmhq_pkg::t_result got);
            bmhq_pkg::t_result want;
            if (due_results.size() == 0) begin
                report($sformatf("result with nothing pending: value %0d status %0d occ %0d",
                                 got.value, got.status, got.occupancy));
            end else begin
                want = due_results.pop_front();
                if (got.value !== want.value)
                    report($sformatf("value got %0d exp %0d", got.value, want.value));
                if (got.status !== want.status)
                    report($sformatf("status got %0d exp %0d", got.status, want.status));
                if (got.occupancy !== want.occupancy)
                    report($sformatf("occupancy got %0d exp %0d", got.occupancy,
                                     want.occupancy));
            end
        endtask

        task flush_leftovers();
            bmhq_pkg::t_result want;
            while (due_results.size() != 0) begin
                want = due_results.pop_front();
                report($sformatf("result never came: value %0d status %0d occ %0d",
                                 want.value, want.status, want.occupancy));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    bmhq_pkg::t_item      i_item;
    bmhq_pkg::t_result    o_result;
    logic                 o_done;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CPW-1:0]       i_cfg_data;

    heap_tracker tracker = new();
    int          cycles  = 0;

    binary_max_heap_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_result    (o_result),
        .o_done      (o_done),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_done === 1'b1) tracker.check_result(o_result);
    end

    function automatic bmhq_pkg::t_item make_item(logic f, logic signed [KW-1:0] k);
        bmhq_pkg::t_item it;
        it.func = f;
        it.key  = k;
        return it;
    endfunction

    function automatic logic signed [KW-1:0] pick_key();
        int v;
        case ($urandom_range(0, 9)) inside
            0: begin
                case ($urandom_range(0, 3))
                    0:       return {1'b1, {(KW - 1){1'b0}}};
                    1:       return {1'b0, {(KW - 1){1'b1}}};
                    2:       return '0;
                    default: return '1;
                endcase
            end
            // narrow range so equal keys meet in the heap
            [1:3]: begin
                v = $urandom_range(0, 15);
                return v - 8;
            end
            default: return $urandom;
        endcase
    endfunction

    // start stays high from one beat to the next when no gap is asked
    task send_item(bmhq_pkg::t_item it, int gap);
        bit taken;
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        taken  = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (busy === 1'b0) taken = 1'b1;
            else @(negedge i_clk);
        end
        tracker.note_item(it);
    endtask

    task drain_queue();
        @(negedge i_clk);
        start = 1'b0;
        do @(posedge i_clk);
        while (tracker.due_results.size() != 0 || busy !== 1'b0);
    endtask

    task write_capacity(logic [CPW-1:0] v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        tracker.capacity = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task run_phase(int n, int idle_pct);
        bmhq_pkg::t_item it;
        int    left;
        int    fill_pct;
        int    seg;
        left     = n;
        fill_pct = 90;
        seg      = $urandom_range(60, n);
        while (left > 0) begin
            if (seg == 0) begin
                seg = $urandom_range(10, 80);
                case ($urandom_range(0, 2))
                    0:       fill_pct = 85;
                    1:       fill_pct = 50;
                    default: fill_pct = 15;
                endcase
                if ($urandom_range(0, 9) == 0) drain_queue();
            end
            it.func = ($urandom_range(0, 99) < fill_pct) ? bmhq_pkg::FUNC_INSERT :
                                                            bmhq_pkg::FUNC_EXTRACT;
            it.key  = pick_key();
            send_item(it, ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, MAX_GAP) : 0);
            seg--;
            left--;
        end
    endtask

    initial begin
        logic [CPW-1:0]   caps [4];
        int               idle_pct;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty heap, key extremes, duplicates, then drain back to empty
        send_item(make_item(bmhq_pkg::FUNC_EXTRACT, $urandom), 0);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, {1'b1, {(KW - 1){1'b0}}}), 0);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, {1'b0, {(KW - 1){1'b1}}}), 1);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, '0), 0);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, '1), 0);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, 1), 2);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, {1'b0, {(KW - 1){1'b1}}}), 0);
        repeat (7) send_item(make_item(bmhq_pkg::FUNC_EXTRACT, $urandom), 0);

        // full heap refuses an insert
        drain_queue();
        write_capacity(7'd2);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, 5), 0);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, 9), 0);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, 7), 0);

        // capacity dropped under the count already held
        drain_queue();
        write_capacity(7'd1);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, 3), 0);
        send_item(make_item(bmhq_pkg::FUNC_EXTRACT, $urandom), 0);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, 4), 0);
        send_item(make_item(bmhq_pkg::FUNC_EXTRACT, $urandom), 0);

        // zero capacity: inserts always refused
        drain_queue();
        write_capacity(7'd0);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, 11), 0);
        send_item(make_item(bmhq_pkg::FUNC_EXTRACT, $urandom), 0);

        // capacity above depth is clipped
        drain_queue();
        write_capacity(7'd127);
        send_item(make_item(bmhq_pkg::FUNC_INSERT, 42), 0);
        send_item(make_item(bmhq_pkg::FUNC_EXTRACT, $urandom), 0);

        for (int mode = 0; mode < 3; mode++) begin
            idle_pct = (mode == 0) ? 38 : (mode == 1) ? 50 : 0;
            caps     = '{7'd127, 7'd64, 7'($urandom_range(1, 64)), 7'd3};
            for (int k = 0; k < 4; k++) begin
                drain_queue();
                write_capacity(caps[k]);
                run_phase(ITEMS_PER_PHASE, idle_pct);
            end
        end

        drain_queue();
        repeat (20) @(posedge i_clk);
        tracker.flush_leftovers();
        if (tracker.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bmhq_pkg.sv
sv/bmhq_ram.sv
sv/bmhq_ctrl.sv
sv/bmhq_dpath.sv
sv/binary_max_heap_queue.sv
sv/bmhq_checker.sv
dv/tb_binary_max_heap_queue.sv
